>>> rtl/core/fcgi_pkg.sv
// fcgi_pkg: types and constants shared by the record deframer modules
// depends on nothing

package fcgi_pkg;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  localparam logic [7:0] TypeEndRequest = 8'd3;
  localparam logic [7:0] TypeStderr     = 8'd7;

  typedef enum logic [3:0] {
    PH_VERSION  = 4'd0,
    PH_TYPE     = 4'd1,
    PH_ID_HI    = 4'd2,
    PH_ID_LO    = 4'd3,
    PH_LEN_HI   = 4'd4,
    PH_LEN_LO   = 4'd5,
    PH_PAD      = 4'd6,
    PH_RESERVED = 4'd7,
    PH_CONTENT  = 4'd8,
    PH_PADDING  = 4'd9
  } phase_e;

  typedef enum logic {
    KIND_CONTENT = 1'b0,
    KIND_END     = 1'b1
  } item_kind_e;

  // one queued operation: a content word, a record end, or both
  typedef struct packed {
    logic        has_content;
    logic        has_end;
    logic [7:0]  data;
    logic [7:0]  rtype;
    logic [15:0] rid;
    logic [15:0] rlen;
  } op_t;

endpackage

>>> rtl/core/fcgi_if.sv
// fcgi_in_if / fcgi_out_if: valid-ready channels of the record deframer
// depends on nothing

interface fcgi_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface fcgi_out_if;
  logic        valid;
  logic        ready;
  logic        item_kind;
  logic [7:0]  payload_byte;
  logic [7:0]  record_type;
  logic [15:0] record_id;
  logic [15:0] record_length;
  logic        response_end;
  logic        last;

  modport source (output valid, output item_kind, output payload_byte, output record_type,
                  output record_id, output record_length, output response_end,
                  output last, input ready);
  modport sink   (input valid, input item_kind, input payload_byte, input record_type,
                  input record_id, input record_length, input response_end,
                  input last, output ready);
endinterface

>>> rtl/core/fastcgi_record_deframer_top.sv
// fastcgi_record_deframer_top: fastcgi response record deframer
// depends on fcgi_pkg, fcgi_if, fcgi_front, fcgi_queue, fcgi_back
//
//   channel  dir  words                 payload
//   in_i     in   one stream byte       data_byte
//   out_o    out  content / record end  item_kind, payload_byte, record_type,
//                                       record_id, record_length, response_end, last
//
// one input word per cycle while the queue has room; a word that gives two
// output words (last content word of a record without padding) is sent as a
// content word and then an end word; the front reaches the back through a
// 4-entry queue; each word passes a queue entry, then the output register
// reset is asynchronous and clears phase, counters, queue and output register
// input stalls only when the queue is full

module fastcgi_record_deframer_top (
  input  logic   clk_i,
  input  logic   rst_ni,
  fcgi_in_if.sink    in_i,
  fcgi_out_if.source out_o
);
  import fcgi_pkg::*;

  logic q_full, q_push, q_pop, q_valid;
  op_t  q_push_op, q_head;

  fcgi_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_data_i  (in_i.data_byte),
    .in_ready_o (in_i.ready),
    .q_full_i   (q_full),
    .push_o     (q_push),
    .push_op_o  (q_push_op)
  );

  fcgi_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (q_push),
    .push_op_i (q_push_op),
    .full_o    (q_full),
    .pop_i     (q_pop),
    .valid_o   (q_valid),
    .head_o    (q_head)
  );

  fcgi_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_valid_i       (q_valid),
    .q_head_i        (q_head),
    .q_pop_o         (q_pop),
    .out_valid_o     (out_o.valid),
    .out_ready_i     (out_o.ready),
    .item_kind_o     (out_o.item_kind),
    .payload_byte_o  (out_o.payload_byte),
    .record_type_o   (out_o.record_type),
    .record_id_o     (out_o.record_id),
    .record_length_o (out_o.record_length),
    .response_end_o  (out_o.response_end),
    .last_o          (out_o.last)
  );

endmodule

>>> rtl/core/fcgi_front.sv
// fcgi_front: header capture and content/padding counting, one word per
// cycle while the queue is not full; depends on fcgi_pkg

module fcgi_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [7:0]        in_data_i,
  output logic              in_ready_o,
  input  logic              q_full_i,
  output logic              push_o,
  output fcgi_pkg::op_t     push_op_o
);
  import fcgi_pkg::*;

  phase_e      phase_q, phase_d;
  logic [7:0]  type_q, type_d;
  logic [15:0] id_q, id_d;
  logic [15:0] len_q, len_d;
  logic [7:0]  pad_q, pad_d;
  logic [15:0] cl_q, cl_d;
  logic [7:0]  pl_q, pl_d;
  logic        accept;
  logic        emit_content, emit_end;
  logic [15:0] cl_dec;
  logic [7:0]  pl_dec;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign cl_dec     = cl_q - 16'd1;
  assign pl_dec     = pl_q - 8'd1;

  always_comb begin
    phase_d      = phase_q;
    type_d       = type_q;
    id_d         = id_q;
    len_d        = len_q;
    pad_d        = pad_q;
    cl_d         = cl_q;
    pl_d         = pl_q;
    emit_content = 1'b0;
    emit_end     = 1'b0;
    case (phase_q)
      PH_TYPE: begin
        type_d  = in_data_i;
        phase_d = PH_ID_HI;
      end
      PH_ID_HI: begin
        id_d    = {in_data_i, id_q[7:0]};
        phase_d = PH_ID_LO;
      end
      PH_ID_LO: begin
        id_d    = {id_q[15:8], in_data_i};
        phase_d = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        len_d   = {in_data_i, len_q[7:0]};
        phase_d = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        len_d   = {len_q[15:8], in_data_i};
        phase_d = PH_PAD;
      end
      PH_PAD: begin
        pad_d   = in_data_i;
        phase_d = PH_RESERVED;
      end
      PH_RESERVED: begin
        cl_d = len_q;
        pl_d = pad_q;
        if (len_q != 16'd0) begin
          phase_d = PH_CONTENT;
        end else if (pad_q != 8'd0) begin
          phase_d = PH_PADDING;
        end else begin
          phase_d  = PH_VERSION;
          emit_end = 1'b1;
        end
      end
      PH_CONTENT: begin
        cl_d         = cl_dec;
        emit_content = 1'b1;
        if (cl_dec == 16'd0) begin
          if (pl_q != 8'd0) begin
            phase_d = PH_PADDING;
          end else begin
            phase_d  = PH_VERSION;
            emit_end = 1'b1;
          end
        end
      end
      PH_PADDING: begin
        pl_d = pl_dec;
        if (pl_dec == 8'd0) begin
          phase_d  = PH_VERSION;
          emit_end = 1'b1;
        end
      end
      default: begin
        phase_d = PH_TYPE;
      end
    endcase
  end

  assign push_o                = accept && (emit_content || emit_end);
  assign push_op_o.has_content = emit_content;
  assign push_op_o.has_end     = emit_end;
  assign push_op_o.data        = in_data_i;
  assign push_op_o.rtype       = type_q;
  assign push_op_o.rid         = id_q;
  assign push_op_o.rlen        = len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_VERSION;
      type_q  <= '0;
      id_q    <= '0;
      len_q   <= '0;
      pad_q   <= '0;
      cl_q    <= '0;
      pl_q    <= '0;
    end else if (accept) begin
      phase_q <= phase_d;
      type_q  <= type_d;
      id_q    <= id_d;
      len_q   <= len_d;
      pad_q   <= pad_d;
      cl_q    <= cl_d;
      pl_q    <= pl_d;
    end
  end

endmodule

>>> rtl/core/fcgi_queue.sv
// fcgi_queue: short fifo of operations between front and back
// depends on fcgi_pkg

module fcgi_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  fcgi_pkg::op_t     push_op_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output fcgi_pkg::op_t     head_o
);
  import fcgi_pkg::*;

  op_t                  mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_q, rd_q;
  logic [QueueCntW-1:0] cnt_q;
  logic                 do_push, do_pop;

  assign full_o  = (cnt_q == QueueCntW'(QueueDepth));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_op_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

>>> rtl/core/fcgi_back.sv
// fcgi_back: output register that expands each operation into one or two words
// depends on fcgi_pkg

module fcgi_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  input  fcgi_pkg::op_t     q_head_i,
  output logic              q_pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              item_kind_o,
  output logic [7:0]        payload_byte_o,
  output logic [7:0]        record_type_o,
  output logic [15:0]       record_id_o,
  output logic [15:0]       record_length_o,
  output logic              response_end_o,
  output logic              last_o
);
  import fcgi_pkg::*;

  op_t        cur_q;
  logic       cur_valid_q;
  logic       sent_q;
  item_kind_e kind;
  logic       fire, finish;

  assign kind   = (cur_q.has_content && !sent_q) ? KIND_CONTENT : KIND_END;
  assign last_o = (kind == KIND_END) || !cur_q.has_end;
  assign fire   = cur_valid_q && out_ready_i;
  assign finish = fire && last_o;

  assign q_pop_o         = q_valid_i && (!cur_valid_q || finish);
  assign out_valid_o     = cur_valid_q;
  assign item_kind_o     = kind;
  assign payload_byte_o  = (kind == KIND_CONTENT) ? cur_q.data : 8'd0;
  assign record_type_o   = cur_q.rtype;
  assign record_id_o     = cur_q.rid;
  assign record_length_o = cur_q.rlen;
  assign response_end_o  = (kind == KIND_END) &&
                           ((cur_q.rtype == TypeEndRequest) || (cur_q.rtype == TypeStderr));

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      cur_q <= q_head_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      sent_q      <= 1'b0;
    end else begin
      if (q_pop_o) begin
        cur_valid_q <= 1'b1;
        sent_q      <= 1'b0;
      end else if (finish) begin
        cur_valid_q <= 1'b0;
      end else if (fire) begin
        sent_q <= 1'b1;
      end
    end
  end

endmodule
